// ===== rtl/core/sbpr_pkg.sv =====
`timescale 1ns / 1ps

package sbpr_pkg;

  // Body buffer and run limits
  localparam int BODY_DEPTH = 32;
  localparam int BODY_AW    = $clog2(BODY_DEPTH);
  localparam int MAX_RUN    = 31;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;
  localparam int IDX_W  = 5;

  // Framing and checksum constants
  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] SUM_GOOD = 8'hFF;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ID_A = 1'b0;
  localparam logic REG_ID_B = 1'b1;

  typedef enum logic [2:0] {
    ST_HDR1,
    ST_HDR2,
    ST_ID,
    ST_LEN,
    ST_BODY,
    ST_EMIT_RD,
    ST_EMIT_WR
  } rx_state_e;

  // Controller to datapath
  typedef struct packed {
    logic ld_id;
    logic ld_len;
    logic ld_body;
    logic start_run;
    logic rd_prime;
    logic emit_en;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_hdr;
    logic id_match;
    logic body_done;
    logic pkt_ok;
    logic slot_free;
    logic emit_last;
  } dp_status_t;

endpackage

// ===== rtl/core/sbpr_rx_if.sv =====
`timescale 1ns / 1ps

interface sbpr_rx_if;
  logic                         valid;
  logic                         ready;
  logic [sbpr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sbpr_pkt_if.sv =====
`timescale 1ns / 1ps

interface sbpr_pkt_if;
  logic                        valid;
  logic                        ready;
  logic [sbpr_pkg::BYTE_W-1:0] packet_id;
  logic [sbpr_pkg::LEN_W-1:0]  packet_length;
  logic [sbpr_pkg::IDX_W-1:0]  byte_index;
  logic [sbpr_pkg::BYTE_W-1:0] body_byte;
  logic                        last;

  modport source (output valid, output packet_id, output packet_length,
                  output byte_index, output body_byte, output last, input ready);
  modport sink (input valid, input packet_id, input packet_length,
                input byte_index, input body_byte, input last, output ready);
endinterface

// ===== rtl/core/servo_bus_packet_receiver.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Handshake          Payload
// rx_i      in    valid / ready      rx_byte
// pkt_o     out   valid / ready      packet_id, packet_length, byte_index, body_byte, last
// apb       in    psel / penable     paddr, pwdata, prdata (ID registers at 0x0 and 0x4)
//
// A received byte is taken while the framing state machine hunts or collects.
// An accepted packet of N body bytes is read out of the body buffer after a step that primes
// the buffer read port; during priming and readout no byte is taken, and rx_i.ready is low.
// A stalled result waits in the output register; reading the next one waits for it.
// Reset is asynchronous and active low; the buffer needs no clearing.
module servo_bus_packet_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbpr_pkg::PADDR_W-1:0]  paddr,
  input  logic [sbpr_pkg::PDATA_W-1:0]  pwdata,
  output logic [sbpr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  sbpr_rx_if.sink                       rx_i,
  sbpr_pkt_if.source                    pkt_o
);

  logic [sbpr_pkg::BYTE_W-1:0] id_a;
  logic [sbpr_pkg::BYTE_W-1:0] id_b;
  sbpr_pkg::dp_cmd_t           dp_cmd;
  sbpr_pkg::dp_status_t        dp_status;

  assign pready = 1'b1;

  sbpr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .id_a_o  (id_a),
    .id_b_o  (id_b)
  );

  sbpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  sbpr_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_i.rx_byte),
    .id_a_i    (id_a),
    .id_b_i    (id_b),
    .cmd_i     (dp_cmd),
    .status_o  (dp_status),
    .pkt_o     (pkt_o)
  );

endmodule

// ===== rtl/core/sbpr_regs.sv =====
`timescale 1ns / 1ps

module sbpr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbpr_pkg::PADDR_W-1:0]   paddr,
  input  logic [sbpr_pkg::PDATA_W-1:0]   pwdata,
  output logic [sbpr_pkg::PDATA_W-1:0]   prdata,
  output logic [sbpr_pkg::BYTE_W-1:0]    id_a_o,
  output logic [sbpr_pkg::BYTE_W-1:0]    id_b_o
);

  logic [sbpr_pkg::BYTE_W-1:0] id_a_q;
  logic [sbpr_pkg::BYTE_W-1:0] id_b_q;
  logic                        wr_en;
  logic                        reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Write the addressed ID register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_a_q <= 8'd1;
      id_b_q <= 8'd2;
    end else if (wr_en) begin
      if (reg_sel == sbpr_pkg::REG_ID_A) begin
        id_a_q <= pwdata[sbpr_pkg::BYTE_W-1:0];
      end else begin
        id_b_q <= pwdata[sbpr_pkg::BYTE_W-1:0];
      end
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    if (reg_sel == sbpr_pkg::REG_ID_A) begin
      prdata[sbpr_pkg::BYTE_W-1:0] = id_a_q;
    end else begin
      prdata[sbpr_pkg::BYTE_W-1:0] = id_b_q;
    end
  end

  assign id_a_o = id_a_q;
  assign id_b_o = id_b_q;

endmodule

// ===== rtl/core/sbpr_ctrl.sv =====
`timescale 1ns / 1ps

module sbpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rx_valid_i,
  output logic                 rx_ready_o,
  input  sbpr_pkg::dp_status_t status_i,
  output sbpr_pkg::dp_cmd_t    cmd_o
);

  sbpr_pkg::rx_state_e state_q, state_d;
  logic                rx_fire;
  logic                emit_load;

  assign rx_fire   = rx_valid_i && rx_ready_o;
  assign emit_load = (state_q == sbpr_pkg::ST_EMIT_WR) && status_i.slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbpr_pkg::ST_HDR1;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbpr_pkg::ST_HDR1: begin
        if (rx_fire) begin
          state_d = status_i.is_hdr ? sbpr_pkg::ST_HDR2 : sbpr_pkg::ST_HDR1;
        end
      end
      sbpr_pkg::ST_HDR2: begin
        if (rx_fire) begin
          state_d = status_i.is_hdr ? sbpr_pkg::ST_ID : sbpr_pkg::ST_HDR1;
        end
      end
      sbpr_pkg::ST_ID: begin
        if (rx_fire) begin
          state_d = status_i.id_match ? sbpr_pkg::ST_LEN : sbpr_pkg::ST_HDR1;
        end
      end
      sbpr_pkg::ST_LEN: begin
        if (rx_fire) begin
          state_d = sbpr_pkg::ST_BODY;
        end
      end
      sbpr_pkg::ST_BODY: begin
        if (rx_fire && status_i.body_done) begin
          state_d = status_i.pkt_ok ? sbpr_pkg::ST_EMIT_RD : sbpr_pkg::ST_HDR1;
        end
      end
      sbpr_pkg::ST_EMIT_RD: begin
        state_d = sbpr_pkg::ST_EMIT_WR;
      end
      sbpr_pkg::ST_EMIT_WR: begin
        if (emit_load && status_i.emit_last) begin
          state_d = sbpr_pkg::ST_HDR1;
        end
      end
      default: begin
        state_d = sbpr_pkg::ST_HDR1;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    rx_ready_o = 1'b0;
    case (state_q)
      sbpr_pkg::ST_HDR1, sbpr_pkg::ST_HDR2: begin
        rx_ready_o = 1'b1;
      end
      sbpr_pkg::ST_ID: begin
        rx_ready_o   = 1'b1;
        cmd_o.ld_id  = rx_valid_i;
      end
      sbpr_pkg::ST_LEN: begin
        rx_ready_o   = 1'b1;
        cmd_o.ld_len = rx_valid_i;
      end
      sbpr_pkg::ST_BODY: begin
        rx_ready_o      = 1'b1;
        cmd_o.ld_body   = rx_valid_i;
        cmd_o.start_run = rx_valid_i && status_i.body_done && status_i.pkt_ok;
      end
      sbpr_pkg::ST_EMIT_RD: begin
        cmd_o.rd_prime = 1'b1;
      end
      sbpr_pkg::ST_EMIT_WR: begin
        cmd_o.emit_en = 1'b1;
      end
      default: begin
        rx_ready_o = 1'b1;
      end
    endcase
  end

  // A run is always primed before the streaming state
  a_prime_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbpr_pkg::ST_EMIT_WR) && ($past(state_q) != sbpr_pkg::ST_EMIT_WR)
    |-> $past(state_q) == sbpr_pkg::ST_EMIT_RD)
    else $error("streaming entered without priming the buffer read");

  // An accepted packet always leads into a run
  a_run_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire && cmd_o.start_run |=> state_q == sbpr_pkg::ST_EMIT_RD)
    else $error("accepted packet did not start a run");

  // No byte is taken while a run is being read out
  a_no_rx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_prime || cmd_o.emit_en) |-> !rx_ready_o)
    else $error("input taken during a run");

endmodule

// ===== rtl/core/sbpr_dp.sv =====
`timescale 1ns / 1ps

module sbpr_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sbpr_pkg::BYTE_W-1:0]  rx_byte_i,
  input  logic [sbpr_pkg::BYTE_W-1:0]  id_a_i,
  input  logic [sbpr_pkg::BYTE_W-1:0]  id_b_i,
  input  sbpr_pkg::dp_cmd_t            cmd_i,
  output sbpr_pkg::dp_status_t         status_o,
  sbpr_pkt_if.source                   pkt_o
);

  localparam int AW = sbpr_pkg::BODY_AW;
  localparam int BW = sbpr_pkg::BYTE_W;
  localparam int IW = sbpr_pkg::IDX_W;

  logic [BW-1:0] held_id_q;
  logic [BW-1:0] held_len_q;
  logic [BW-1:0] body_count_q;
  logic [BW-1:0] sum_q;
  logic [BW-1:0] body_mem [sbpr_pkg::BODY_DEPTH];
  logic [BW-1:0] rd_data_q;
  logic [IW-1:0] emit_idx_q;

  logic          out_valid_q;
  logic [BW-1:0] out_id_q;
  logic [IW-1:0] out_len_q;
  logic [IW-1:0] out_idx_q;
  logic [BW-1:0] out_byte_q;
  logic          out_last_q;

  logic [BW-1:0] count_nxt;
  logic [BW-1:0] sum_nxt;
  logic          emit_load;
  logic          emit_last;
  logic          rd_en;
  logic [IW-1:0] rd_idx;

  assign count_nxt = body_count_q + 8'd1;
  assign sum_nxt   = sum_q + rx_byte_i;
  assign emit_last = (emit_idx_q == (held_len_q[IW-1:0] - 5'd1));
  assign emit_load = cmd_i.emit_en && (!out_valid_q || pkt_o.ready);
  assign rd_en     = cmd_i.rd_prime || emit_load;
  assign rd_idx    = cmd_i.rd_prime ? emit_idx_q : (emit_idx_q + 5'd1);

  // Status for the controller
  always_comb begin
    status_o.is_hdr    = (rx_byte_i == sbpr_pkg::HDR_BYTE);
    status_o.id_match  = (rx_byte_i == id_a_i) || (rx_byte_i == id_b_i);
    status_o.body_done = (count_nxt == held_len_q);
    status_o.pkt_ok    = (sum_nxt == sbpr_pkg::SUM_GOOD)
                         && (count_nxt < 8'(sbpr_pkg::BODY_DEPTH))
                         && (held_len_q <= 8'(sbpr_pkg::MAX_RUN))
                         && (held_len_q != 8'd0);
    status_o.slot_free = !out_valid_q || pkt_o.ready;
    status_o.emit_last = emit_last;
  end

  // Hold packet header and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_id_q    <= '0;
      held_len_q   <= '0;
      body_count_q <= '0;
      sum_q        <= '0;
    end else begin
      if (cmd_i.ld_id) begin
        held_id_q <= rx_byte_i;
        sum_q     <= rx_byte_i;
      end
      if (cmd_i.ld_len) begin
        held_len_q   <= rx_byte_i;
        body_count_q <= '0;
        sum_q        <= sum_nxt;
      end
      if (cmd_i.ld_body) begin
        body_count_q <= count_nxt;
        sum_q        <= sum_nxt;
      end
    end
  end

  // Store body bytes that fit in the buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_body && (body_count_q < 8'(sbpr_pkg::BODY_DEPTH))) begin
      body_mem[body_count_q[AW-1:0]] <= rx_byte_i;
    end
  end

  // Read the next body byte ahead of the output register
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= body_mem[AW'(rd_idx)];
    end
  end

  // Advance through the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_idx_q <= '0;
    end else if (cmd_i.start_run) begin
      emit_idx_q <= '0;
    end else if (emit_load) begin
      emit_idx_q <= emit_idx_q + 5'd1;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (pkt_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_id_q   <= held_id_q;
      out_len_q  <= held_len_q[IW-1:0];
      out_idx_q  <= emit_idx_q;
      out_byte_q <= rd_data_q;
      out_last_q <= emit_last;
    end
  end

  assign pkt_o.valid         = out_valid_q;
  assign pkt_o.packet_id     = out_id_q;
  assign pkt_o.packet_length = out_len_q;
  assign pkt_o.byte_index    = out_idx_q;
  assign pkt_o.body_byte     = out_byte_q;
  assign pkt_o.last          = out_last_q;

  // Runs only cover lengths that fit one run
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_en |-> (held_len_q != 8'd0) && (held_len_q <= 8'(sbpr_pkg::MAX_RUN)))
    else $error("run started for an out-of-range length");

  // The run index never passes the packet length
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_en |-> ({3'b000, emit_idx_q} < held_len_q))
    else $error("run index beyond packet length");

  // Priming always reads the first body byte
  a_prime_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_prime |-> (emit_idx_q == 5'd0))
    else $error("run primed at a non-zero index");

endmodule
